// ----- hdl/systematic_particle_resampler_assert.svh -----
// assertion macros used by the resampler rtl
`ifndef SYSTEMATIC_PARTICLE_RESAMPLER_ASSERT_SVH
`define SYSTEMATIC_PARTICLE_RESAMPLER_ASSERT_SVH

// property that must hold on every clock edge out of reset
`define SPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition in one cycle implies a check in the next
`define SPR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// ----- hdl/spr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package spr_pkg;

  localparam int MAX_PARTICLES = 1024;
  localparam int WEIGHT_BITS   = 24;

  localparam int IN_WEIGHT_W  = 24;
  localparam int RAND_W       = 16;
  localparam int OUT_INDEX_W  = 10;
  localparam int SUM_W        = 32;

  localparam int IDX_W   = $clog2(MAX_PARTICLES);
  localparam int CNT_W   = $clog2(MAX_PARTICLES + 1);
  localparam int STORE_W = (WEIGHT_BITS < IN_WEIGHT_W) ? WEIGHT_BITS : IN_WEIGHT_W;
  localparam int DIV_W   = WEIGHT_BITS + 1;
  localparam int DEN_W   = CNT_W + 1;
  localparam int DCNT_W  = $clog2(DIV_W + 1);
  localparam int OFS_W   = RAND_W + WEIGHT_BITS;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  typedef struct packed {
    logic                   func;
    logic                   first;
    logic [IN_WEIGHT_W-1:0] weight;
    logic [RAND_W-1:0]      random_value;
  } in_item_t;

  typedef struct packed {
    logic [OUT_INDEX_W-1:0] selected_index;
    logic                   last;
    logic                   overrun;
    logic                   empty_res;
  } out_item_t;

endpackage

`default_nettype wire

// ----- hdl/spr_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface spr_in_if import spr_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface spr_out_if import spr_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/systematic_particle_resampler.sv -----
// load beat: taken while idle and written to the weight memory, no result
// draw beat: CHECK, then ADD and CHECK per step of the cumulative walk (one weight memory read and add), then EMIT
// first draw of a round adds two passes of the shared restoring divider (offset, then step) and a fetch
// a result waiting in the output register does not stop the next beat being taken
// reset (async, active low) clears counters and control; the weight memory is not cleared
`timescale 1ns / 1ps
`default_nettype none

`include "systematic_particle_resampler_assert.svh"

module systematic_particle_resampler import spr_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  spr_in_if.sink     in_i,
  spr_out_if.source  out_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FETCH,
    ST_CHECK,
    ST_ADD,
    ST_EMIT
  } state_e;

  state_e              state_q;
  logic [CNT_W-1:0]    loaded_q;
  logic [CNT_W-1:0]    draw_q;
  logic [IDX_W-1:0]    walk_q;
  logic [SUM_W-1:0]    cum_q;
  logic [SUM_W-1:0]    u_q;
  logic [SUM_W-1:0]    step_q;
  logic                div_phase_q;
  logic [DCNT_W-1:0]   div_cnt_q;
  logic [DEN_W-1:0]    rem_q;
  logic [DIV_W-1:0]    num_q;
  logic [DEN_W-1:0]    den_q;
  out_item_t           res_q;
  out_item_t           out_q;
  logic                out_valid_q;

  logic [STORE_W-1:0]  mem [MAX_PARTICLES];
  logic [STORE_W-1:0]  rdata_q;

  logic                in_fire;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic                load_ok;
  logic                emit_go;

  logic [DEN_W:0]      rem_sh;
  logic                rem_ge;
  logic [DEN_W-1:0]    rem_nx;
  logic [DIV_W-1:0]    num_nx;
  logic                div_last;
  logic [DIV_W-1:0]    ofs_num;
  logic [DIV_W-1:0]    step_num;

  logic                walk_more;
  logic                is_last;
  logic [SUM_W:0]      sum_wide;
  logic [SUM_W-1:0]    sum_sat;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign load_ok = in_i.data.first || (loaded_q < CNT_W'(MAX_PARTICLES));
  assign wr_en   = in_fire && (in_i.data.func == FUNC_LOAD) && load_ok;
  assign wr_addr = in_i.data.first ? '0 : loaded_q[IDX_W-1:0];
  assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);

  // restoring divider step
  assign rem_sh   = {rem_q, num_q[DIV_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, den_q};
  assign rem_nx   = rem_ge ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
  assign num_nx   = {num_q[DIV_W-2:0], rem_ge};
  assign div_last = (div_cnt_q == DCNT_W'(DIV_W - 1));
  assign ofs_num  = DIV_W'((OFS_W'(in_i.data.random_value) << WEIGHT_BITS) >> RAND_W);
  assign step_num = DIV_W'(1) << WEIGHT_BITS;

  assign walk_more = (u_q > cum_q) && ((CNT_W'(walk_q) + 1'b1) < loaded_q);
  assign is_last   = ((draw_q + 1'b1) >= loaded_q);
  assign sum_wide  = {1'b0, cum_q} + (SUM_W + 1)'(rdata_q);
  assign sum_sat   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

  assign rd_en   = ((state_q == ST_DIV) && div_phase_q && div_last)
                || ((state_q == ST_CHECK) && walk_more);
  assign rd_addr = (state_q == ST_CHECK) ? walk_q + 1'b1 : '0;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= in_i.data.weight[STORE_W-1:0];
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      loaded_q    <= '0;
      draw_q      <= '0;
      walk_q      <= '0;
      cum_q       <= '0;
      u_q         <= '0;
      step_q      <= '0;
      div_phase_q <= 1'b0;
      div_cnt_q   <= '0;
      rem_q       <= '0;
      num_q       <= '0;
      den_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_i.data.func == FUNC_LOAD) begin
              if (load_ok) begin
                loaded_q <= in_i.data.first ? CNT_W'(1) : loaded_q + 1'b1;
              end
              draw_q <= '0;
            end else if (loaded_q == '0) begin
              res_q   <= '{selected_index: '0, last: 1'b0, overrun: 1'b0, empty_res: 1'b1};
              state_q <= ST_EMIT;
            end else if (draw_q == '0) begin
              // new round: offset first, then step
              num_q       <= ofs_num;
              den_q       <= DEN_W'(loaded_q) + 1'b1;
              rem_q       <= '0;
              div_cnt_q   <= '0;
              div_phase_q <= 1'b0;
              state_q     <= ST_DIV;
            end else begin
              state_q <= ST_CHECK;
            end
          end
        end
        ST_DIV: begin
          if (div_last) begin
            rem_q     <= '0;
            div_cnt_q <= '0;
            if (!div_phase_q) begin
              u_q         <= SUM_W'(num_nx);
              num_q       <= step_num;
              den_q       <= DEN_W'(loaded_q);
              div_phase_q <= 1'b1;
            end else begin
              step_q  <= SUM_W'(num_nx);
              state_q <= ST_FETCH;
            end
          end else begin
            rem_q     <= rem_nx;
            num_q     <= num_nx;
            div_cnt_q <= div_cnt_q + 1'b1;
          end
        end
        ST_FETCH: begin
          cum_q   <= SUM_W'(rdata_q);
          walk_q  <= '0;
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (walk_more) begin
            state_q <= ST_ADD;
          end else begin
            res_q   <= '{selected_index: OUT_INDEX_W'(walk_q), last: is_last,
                         overrun: (u_q > cum_q), empty_res: 1'b0};
            u_q     <= u_q + step_q;
            draw_q  <= is_last ? '0 : draw_q + 1'b1;
            state_q <= ST_EMIT;
          end
        end
        ST_ADD: begin
          cum_q   <= sum_sat;
          walk_q  <= walk_q + 1'b1;
          state_q <= ST_CHECK;
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_q   <= res_q;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `SPR_ASSERT(a_empty_clean, (out_valid_q && out_q.empty_res) |-> (!out_q.last && !out_q.overrun && (out_q.selected_index == '0)), "empty beat carries draw data")
  `SPR_ASSERT_NEXT(a_sum_monotone, (state_q == ST_ADD), (cum_q >= $past(cum_q)), "cumulative sum decreased")
  `SPR_ASSERT(a_overrun_at_end, (state_q == ST_CHECK && !walk_more && (u_q > cum_q)) |-> ((CNT_W'(walk_q) + 1'b1) == loaded_q), "overrun before last index")
  `SPR_ASSERT(a_div_range, (state_q == ST_DIV) |-> (div_cnt_q < DCNT_W'(DIV_W)), "divider count out of range")

endmodule

`default_nettype wire
